### rtl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same, but also checked while reset is held
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/vrpc_pkg.sv
// Types and constants of the vertex rotate, project and clip pipeline
package vrpc_pkg;

   localparam int TRIG_W      = 18;
   localparam int ZOOM_W      = 12;
   localparam int WIN_W       = 11;
   localparam int WORLD_W     = 15;
   localparam int ROT_W       = 18;
   localparam int PIT_W       = 20;
   localparam int SH_W        = 22;
   localparam int REM_W       = 33;
   localparam int DEN_W       = 19;
   localparam int QUO_W       = 14;
   localparam int FAC_W       = 20;
   localparam int PRD_W       = SH_W + FAC_W;
   localparam int CRD_W       = 29;
   localparam int SCR_W       = 13;
   localparam int DEP_W       = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int DIV_STEPS   = QUO_W / 2;

   localparam int ROT_SHIFT   = 16;
   localparam int ZOOM_SHIFT  = 11;
   localparam int PERSP_SHIFT = 14;
   localparam int PERSP_ONE   = 16384;
   localparam int COMP_KNEE   = PERSP_ONE / 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_COS_YAW     = 3'd0,
      REG_SIN_YAW     = 3'd1,
      REG_COS_PITCH   = 3'd2,
      REG_SIN_PITCH   = 3'd3,
      REG_ZOOM        = 3'd4,
      REG_PERSPECTIVE = 3'd5,
      REG_WIDTH       = 3'd6,
      REG_HEIGHT      = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic signed [TRIG_W-1:0] cos_yaw;
      logic signed [TRIG_W-1:0] sin_yaw;
      logic signed [TRIG_W-1:0] cos_pitch;
      logic signed [TRIG_W-1:0] sin_pitch;
   } rot_cfg_type;

   typedef struct packed {
      logic [REM_W-1:0]        rem;
      logic [DEN_W-1:0]        den;
      logic [QUO_W-1:0]        quo;
      logic                    comp;
      logic signed [PIT_W-1:0] d;
      logic signed [SH_W-1:0]  shx;
      logic signed [SH_W-1:0]  shy;
   } div_item_type;

endpackage

### rtl/vertex_rotate_project_clip.sv
// Top level: registers, zoom, divider chain, perspective scale, clipping
// Stages: rotate, zoom, divider chain, perspective multiply, clip and output register.
// Throughput: one item per cycle while rsp_stall is low; every stage holds one item and moves on
//   whenever the stage after it is empty or moving, so bubbles close up.
// Reset: synchronous; empties every stage and loads the register defaults.
module vertex_rotate_project_clip import vrpc_pkg::*; #(
   parameter int MAX_SCREEN_WIDTH = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [TRIG_W-1:0]          csr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [WORLD_W-1:0]  req_world_dx,
   input  logic signed [WORLD_W-1:0]  req_world_dy,
   input  logic signed [WORLD_W-1:0]  req_world_dz,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SCR_W-1:0]    rsp_screen_x,
   output logic signed [SCR_W-1:0]    rsp_screen_y,
   output logic signed [DEP_W-1:0]    rsp_depth,
   output logic                       rsp_clip_left,
   output logic                       rsp_clip_right,
   output logic                       rsp_clip_top,
   output logic                       rsp_clip_bottom
);
`include "assert_macros.svh"

   localparam logic signed [CRD_W-1:0] NEG_MAX = CRD_W'(-MAX_SCREEN_WIDTH);
   localparam logic signed [CRD_W-1:0] TWO_MAX = CRD_W'(2 * MAX_SCREEN_WIDTH);

   // configuration registers
   rot_cfg_type       rot_cfg_ff;
   logic [ZOOM_W-1:0] zoom_ff;
   logic              persp_ff;
   logic [WIN_W-1:0]  width_ff, height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_cfg_ff.cos_yaw   <= TRIG_W'(65536);
         rot_cfg_ff.sin_yaw   <= '0;
         rot_cfg_ff.cos_pitch <= TRIG_W'(65536);
         rot_cfg_ff.sin_pitch <= '0;
         zoom_ff              <= ZOOM_W'(256);
         persp_ff             <= 1'b0;
         width_ff             <= WIN_W'(640);
         height_ff            <= WIN_W'(480);
      end else if (csr_write) begin
         case (csr_reg_type'(csr_index))
            REG_COS_YAW:     rot_cfg_ff.cos_yaw   <= csr_data;
            REG_SIN_YAW:     rot_cfg_ff.sin_yaw   <= csr_data;
            REG_COS_PITCH:   rot_cfg_ff.cos_pitch <= csr_data;
            REG_SIN_PITCH:   rot_cfg_ff.sin_pitch <= csr_data;
            REG_ZOOM:        zoom_ff              <= csr_data[ZOOM_W-1:0];
            REG_PERSPECTIVE: persp_ff             <= csr_data[0];
            REG_WIDTH:       width_ff             <= csr_data[WIN_W-1:0];
            REG_HEIGHT:      height_ff            <= csr_data[WIN_W-1:0];
            default: ;
         endcase
      end
   end

   // rotation
   logic                    rot_valid, rot_ready, rot_in_ready;
   logic signed [ROT_W-1:0] rot_a;
   logic signed [PIT_W-1:0] rot_c, rot_d;

   vrpc_rotate u_rotate (
      .clock     (clock),
      .reset     (reset),
      .cfg       (rot_cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (rot_in_ready),
      .in_dx     (req_world_dx),
      .in_dy     (req_world_dy),
      .in_dz     (req_world_dz),
      .out_valid (rot_valid),
      .out_ready (rot_ready),
      .out_a     (rot_a),
      .out_c     (rot_c),
      .out_d     (rot_d)
   );

   assign req_stall = !rot_in_ready;

   // zoom and divider setup
   logic                    zm_valid_ff;
   div_item_type            zm_item_ff, zm_item_in;
   logic                    zm_en;
   logic signed [ZOOM_W:0]  zoom_s;
   logic signed [30:0]      zx_prod;
   logic signed [32:0]      zy_prod;
   logic signed [PIT_W:0]   den_sum;

   logic         chain_valid [0:DIV_STEPS];
   logic         chain_ready [0:DIV_STEPS];
   div_item_type chain_item  [0:DIV_STEPS];

   assign zoom_s  = $signed({1'b0, zoom_ff});
   assign zx_prod = zoom_s * rot_a;
   assign zy_prod = zoom_s * rot_c;
   assign den_sum = (PIT_W+1)'(rot_d) + (PIT_W+1)'(PERSP_ONE);

   always_comb begin
      zm_item_in.shx  = SH_W'(zx_prod >>> ZOOM_SHIFT);
      zm_item_in.shy  = SH_W'(zy_prod >>> ZOOM_SHIFT);
      zm_item_in.d    = rot_d;
      zm_item_in.comp = persp_ff && (rot_d > PIT_W'(COMP_KNEE));
      zm_item_in.den  = den_sum[DEN_W-1:0];
      zm_item_in.rem  = {rot_d[REM_W-PERSP_SHIFT-1:0], PERSP_SHIFT'(0)};
      zm_item_in.quo  = '0;
   end

   assign zm_en     = !zm_valid_ff || chain_ready[0];
   assign rot_ready = zm_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         zm_valid_ff <= 1'b0;
      end else if (zm_en) begin
         zm_valid_ff <= rot_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (zm_en) begin
         zm_item_ff <= zm_item_in;
      end
   end

   assign chain_valid[0] = zm_valid_ff;
   assign chain_item[0]  = zm_item_ff;

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      vrpc_div_step #(
         .TOP_BIT (QUO_W - 1 - 2 * k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_item   (chain_item[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_item  (chain_item[k+1])
      );
   end

   // perspective scale
   logic                     ps_valid_ff, ps_en;
   logic signed [PRD_W-1:0]  px_ff, py_ff;
   logic signed [PIT_W-1:0]  dd_ff;
   logic signed [PIT_W-1:0]  dd_in;
   logic signed [PIT_W:0]    fac_sum;
   logic signed [FAC_W-1:0]  fac;
   div_item_type             dv;

   assign dv      = chain_item[DIV_STEPS];
   assign dd_in   = dv.comp ? $signed(PIT_W'(dv.quo)) : dv.d;
   assign fac_sum = (PIT_W+1)'(PERSP_ONE) - (PIT_W+1)'(dd_in);
   // a unit factor leaves the offsets untouched when perspective is off
   assign fac     = persp_ff ? FAC_W'(fac_sum) : FAC_W'(PERSP_ONE);

   logic cl_en;
   assign ps_en                  = !ps_valid_ff || cl_en;
   assign chain_ready[DIV_STEPS] = ps_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         ps_valid_ff <= 1'b0;
      end else if (ps_en) begin
         ps_valid_ff <= chain_valid[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (ps_en) begin
         px_ff <= dv.shx * fac;
         py_ff <= dv.shy * fac;
         dd_ff <= dd_in;
      end
   end

   // centre, clip and output register
   logic                     out_valid_ff;
   logic signed [SCR_W-1:0]  sx_ff, sy_ff;
   logic signed [DEP_W-1:0]  dep_ff;
   logic                     cl_ff, cr_ff, ct_ff, cb_ff;

   logic signed [CRD_W-1:0]  cx, cy, cx_sat, cy_sat;
   logic                     cl_in, cr_in, ct_in, cb_in;
   logic signed [DEP_W-1:0]  dep_in;

   assign cx = $signed(CRD_W'(width_ff >> 1)) + CRD_W'(px_ff >>> PERSP_SHIFT);
   assign cy = $signed(CRD_W'(height_ff >> 1)) - CRD_W'(py_ff >>> PERSP_SHIFT);

   always_comb begin
      cl_in  = 1'b0;
      cr_in  = 1'b0;
      cx_sat = cx;
      if (cx < 0) begin
         cl_in = 1'b1;
         if (cx < NEG_MAX) cx_sat = NEG_MAX;
      end else if (cx >= $signed(CRD_W'(width_ff))) begin
         cr_in = 1'b1;
         if (cx > TWO_MAX) cx_sat = TWO_MAX;
      end
      ct_in  = 1'b0;
      cb_in  = 1'b0;
      cy_sat = cy;
      if (cy < 0) begin
         ct_in = 1'b1;
         if (cy < NEG_MAX) cy_sat = NEG_MAX;
      end else if (cy >= $signed(CRD_W'(height_ff))) begin
         cb_in = 1'b1;
         if (cy > TWO_MAX) cy_sat = TWO_MAX;
      end
      if (dd_ff > PIT_W'(32767)) begin
         dep_in = DEP_W'(32767);
      end else if (dd_ff < -PIT_W'(32768)) begin
         dep_in = DEP_W'(-32768);
      end else begin
         dep_in = DEP_W'(dd_ff);
      end
   end

   assign cl_en = !out_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cl_en) begin
         out_valid_ff <= ps_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cl_en) begin
         sx_ff  <= SCR_W'(cx_sat);
         sy_ff  <= SCR_W'(cy_sat);
         dep_ff <= dep_in;
         cl_ff  <= cl_in;
         cr_ff  <= cr_in;
         ct_ff  <= ct_in;
         cb_ff  <= cb_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_screen_x    = sx_ff;
   assign rsp_screen_y    = sy_ff;
   assign rsp_depth       = dep_ff;
   assign rsp_clip_left   = cl_ff;
   assign rsp_clip_right  = cr_ff;
   assign rsp_clip_top    = ct_ff;
   assign rsp_clip_bottom = cb_ff;

   `ASSERT_CLK(a_clip_x_excl, clock, reset, rsp_valid |-> !(rsp_clip_left && rsp_clip_right), "left and right clip both set")
   `ASSERT_CLK(a_clip_left_neg, clock, reset, (rsp_valid && rsp_clip_left) |-> rsp_screen_x[SCR_W-1], "left clip with non-negative x")
   `ASSERT_CLK(a_stall_full, clock, reset, req_stall |-> (rsp_valid && rsp_stall), "input stalled while output free")
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid straight after reset")

endmodule

### rtl/vrpc_rotate.sv
// Four-stage yaw and pitch rotation of a world offset
module vrpc_rotate import vrpc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  rot_cfg_type               cfg,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [WORLD_W-1:0] in_dx,
   input  logic signed [WORLD_W-1:0] in_dy,
   input  logic signed [WORLD_W-1:0] in_dz,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic signed [ROT_W-1:0]   out_a,
   output logic signed [PIT_W-1:0]   out_c,
   output logic signed [PIT_W-1:0]   out_d
);

   logic [3:0] valid_ff;
   logic [3:0] en;

   // stage 1: yaw products
   logic signed [32:0] pcx_ff, psz_ff, psx_ff, pcz_ff;
   logic signed [WORLD_W-1:0] dy1_ff;
   // stage 2: yaw sums
   logic signed [ROT_W-1:0] a2_ff, b2_ff;
   logic signed [WORLD_W-1:0] dy2_ff;
   // stage 3: pitch products
   logic signed [32:0] qcy_ff, qsy_ff;
   logic signed [35:0] qsb_ff, qcb_ff;
   logic signed [ROT_W-1:0] a3_ff;
   // stage 4: pitch sums
   logic signed [ROT_W-1:0] a4_ff;
   logic signed [PIT_W-1:0] c4_ff, d4_ff;

   logic signed [33:0] a_sum_in, b_sum_in;
   logic signed [36:0] c_sum_in, d_sum_in;

   assign en[3]    = !valid_ff[3] || out_ready;
   assign en[2]    = !valid_ff[2] || en[3];
   assign en[1]    = !valid_ff[1] || en[2];
   assign en[0]    = !valid_ff[0] || en[1];
   assign in_ready = en[0];

   assign a_sum_in = 34'(pcx_ff) - 34'(psz_ff);
   assign b_sum_in = 34'(psx_ff) + 34'(pcz_ff);
   assign c_sum_in = 37'(qcy_ff) - 37'(qsb_ff);
   assign d_sum_in = 37'(qsy_ff) + 37'(qcb_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[0]) valid_ff[0] <= in_valid;
         if (en[1]) valid_ff[1] <= valid_ff[0];
         if (en[2]) valid_ff[2] <= valid_ff[1];
         if (en[3]) valid_ff[3] <= valid_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         pcx_ff <= $signed(cfg.cos_yaw) * in_dx;
         psz_ff <= $signed(cfg.sin_yaw) * in_dz;
         psx_ff <= $signed(cfg.sin_yaw) * in_dx;
         pcz_ff <= $signed(cfg.cos_yaw) * in_dz;
         dy1_ff <= in_dy;
      end
      if (en[1]) begin
         a2_ff  <= ROT_W'(a_sum_in >>> ROT_SHIFT);
         b2_ff  <= ROT_W'(b_sum_in >>> ROT_SHIFT);
         dy2_ff <= dy1_ff;
      end
      if (en[2]) begin
         qcy_ff <= $signed(cfg.cos_pitch) * dy2_ff;
         qsy_ff <= $signed(cfg.sin_pitch) * dy2_ff;
         qsb_ff <= $signed(cfg.sin_pitch) * b2_ff;
         qcb_ff <= $signed(cfg.cos_pitch) * b2_ff;
         a3_ff  <= a2_ff;
      end
      if (en[3]) begin
         c4_ff <= PIT_W'(c_sum_in >>> ROT_SHIFT);
         d4_ff <= PIT_W'(d_sum_in >>> ROT_SHIFT);
         a4_ff <= a3_ff;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_a     = a4_ff;
   assign out_c     = c4_ff;
   assign out_d     = d4_ff;

endmodule

### rtl/vrpc_div_step.sv
// One pipeline stage of the depth compression divider: two quotient bits
module vrpc_div_step import vrpc_pkg::*; #(
   parameter int TOP_BIT = 13
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  div_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output div_item_type out_item
);

   logic         valid_ff;
   div_item_type item_ff;
   div_item_type item_in;
   logic         en;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   // restoring division: subtract the shifted divisor where it fits
   always_comb begin
      logic [REM_W-1:0] sub;
      item_in = in_item;
      for (int j = 0; j < 2; j++) begin
         sub = REM_W'(in_item.den) << (TOP_BIT - j);
         if (item_in.rem >= sub) begin
            item_in.rem = item_in.rem - sub;
            item_in.quo[TOP_BIT - j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
